>>> hw/rtl/fla_pkg.sv
// Package for the free-list handle allocator: opcodes, status codes, FSM states.
// No dependencies; used by the request and response interfaces and the allocator core.
package fla_pkg;

  localparam int unsigned OpcodeWidth = 2;
  localparam int unsigned HandleWidth = 9;
  localparam int unsigned ResultWidth = 8;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [OpcodeWidth-1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE      = 2'd1,
    OP_QUERY     = 2'd2,
    OP_RESET_ALL = 2'd3
  } opcode_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

>>> hw/rtl/fla_req_if.sv
// Request channel of the handle allocator: valid/ready plus request fields.
// Depends on fla_pkg.
interface fla_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [fla_pkg::OpcodeWidth-1:0]        opcode;
  logic signed [fla_pkg::HandleWidth-1:0] handle;
  logic                                   object_nonempty;

  modport source (output valid, output opcode, output handle, output object_nonempty,
                  input ready);
  modport sink   (input valid, input opcode, input handle, input object_nonempty,
                  output ready);
endinterface

>>> hw/rtl/fla_rsp_if.sv
// Response channel of the handle allocator: valid/ready plus result fields.
// Depends on fla_pkg.
interface fla_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [fla_pkg::ResultWidth-1:0]  result_handle;
  logic [fla_pkg::StatusWidth-1:0]  status;

  modport source (output valid, output result_handle, output status, input ready);
  modport sink   (input valid, input result_handle, input status, output ready);
endinterface

>>> hw/rtl/free_list_handle_allocator_core.sv
// Handle allocator with a LIFO free list kept in a slot RAM and a high-water mark.
// Depends on fla_pkg, fla_req_if, fla_rsp_if and fla_ram.
//
//   channel | dir | fields
//   req_i   | in  | opcode, handle, object_nonempty
//   rsp_o   | out | result_handle, status
//
// For each request the slot RAM is read in the transfer cycle; the entry is updated and
// the response registered in the execute state, once the previous response is taken.
// One request is in flight at a time; the next transfer waits for the RAM update.
// A stalled response does not block the next transfer, but holds its execute state until taken.
// Reset empties the free list and clears the high-water mark; the RAM needs no clearing.
module free_list_handle_allocator_core #(
  parameter int unsigned POOL_SLOTS = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fla_req_if.sink  req_i,
  fla_rsp_if.source rsp_o
);
  import fla_pkg::*;

  localparam int unsigned IdxW  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned HwW   = IdxW + 1;
  localparam int unsigned CmpW  = (HwW > 8) ? HwW : 8;
  localparam int unsigned WordW = IdxW + 2;
  localparam logic [HwW-1:0] PoolLimit = HwW'(POOL_SLOTS);

  // RAM word: {live, link_empty, link_idx}
  state_e                 state_q, state_d;
  logic [HwW-1:0]         high_water_q, high_water_d;
  logic                   head_empty_q, head_empty_d;
  logic [IdxW-1:0]        head_idx_q, head_idx_d;
  opcode_e                op_q;
  logic [HandleWidth-1:0] handle_q;
  logic                   nonempty_q;
  logic                   out_valid_q, out_valid_d;
  logic [ResultWidth-1:0] result_q, result_d;
  status_e                status_q, status_d;

  logic                   accept;
  logic [CmpW-1:0]        in_h_ext, h_ext, hw_ext, idx_ext;
  logic [IdxW-1:0]        raddr, waddr, alloc_idx;
  logic                   we;
  logic [WordW-1:0]       wdata, rdata;
  logic                   h_live;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign in_h_ext = CmpW'(req_i.handle[7:0]);
  assign raddr    = (opcode_e'(req_i.opcode) == OP_ALLOC) ? head_idx_q : in_h_ext[IdxW-1:0];

  fla_ram #(
    .Width (WordW),
    .Depth (POOL_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign h_ext  = CmpW'(handle_q[7:0]);
  assign hw_ext = CmpW'(high_water_q);
  assign h_live = !handle_q[HandleWidth-1] && (h_ext < hw_ext) && rdata[IdxW+1];

  always_comb begin
    state_d      = state_q;
    high_water_d = high_water_q;
    head_empty_d = head_empty_q;
    head_idx_d   = head_idx_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    result_d     = result_q;
    status_d     = status_q;
    we           = 1'b0;
    waddr        = h_ext[IdxW-1:0];
    wdata        = {1'b0, head_empty_q, head_idx_q};
    alloc_idx    = head_idx_q;
    idx_ext      = CmpW'(head_idx_q);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_q || rsp_o.ready) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          result_d    = handle_q[7:0];
          status_d    = ST_OK;
          unique case (op_q)
            OP_ALLOC: begin
              if (!head_empty_q) begin
                alloc_idx    = head_idx_q;
                head_empty_d = rdata[IdxW];
                head_idx_d   = rdata[IdxW-1:0];
                we           = 1'b1;
              end else if (high_water_q < PoolLimit) begin
                alloc_idx    = high_water_q[IdxW-1:0];
                high_water_d = high_water_q + HwW'(1);
                we           = 1'b1;
              end else begin
                status_d = ST_FULL;
              end
              idx_ext = CmpW'(alloc_idx);
              if (we) begin
                result_d = idx_ext[7:0];
              end
              waddr = alloc_idx;
              wdata = {nonempty_q, 1'b1, {IdxW{1'b0}}};
            end
            OP_FREE: begin
              if (h_live) begin
                we           = 1'b1;
                head_empty_d = 1'b0;
                head_idx_d   = h_ext[IdxW-1:0];
              end else begin
                status_d = ST_INVALID;
              end
            end
            OP_QUERY: begin
              status_d = h_live ? ST_OK : ST_INVALID;
            end
            OP_RESET_ALL: begin
              high_water_d = '0;
              head_empty_d = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      high_water_q <= '0;
      head_empty_q <= 1'b1;
      head_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      high_water_q <= high_water_d;
      head_empty_q <= head_empty_d;
      head_idx_q   <= head_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= opcode_e'(req_i.opcode);
      handle_q   <= req_i.handle;
      nonempty_q <= req_i.object_nonempty;
    end
    result_q <= result_d;
    status_q <= status_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result_handle = result_q;
  assign rsp_o.status        = status_q;

`ifndef SYNTHESIS
  a_hw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    high_water_q <= PoolLimit)
    else $error("high-water mark beyond pool size");

  a_head_below_hw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_empty_q |-> (HwW'(head_idx_q) < high_water_q))
    else $error("free-list head at or above high-water mark");

  a_transfer_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("request transfer did not start execution");
`endif

endmodule

>>> hw/rtl/fla_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
